>>> hw/rtl/jsbm_pkg.sv
// Shared types and constants for the JPEG scan byte mutator.
// No dependencies; used by the parser, the queue, the mutator and the top level.
package jsbm_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [3:0] LEVEL_RESET = 4'd5;
   localparam logic [3:0] FLIP_BASE   = 4'd10;
   localparam logic [3:0] ROTATE_LIMIT = 4'd7;

   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] BYTE_FE   = 8'hFE;
   localparam logic [7:0] BYTE_00   = 8'h00;
   localparam logic [7:0] MARK_SOS  = 8'hDA;
   localparam logic [7:0] MARK_EOI  = 8'hD9;
   localparam logic [7:0] MARK_RST0 = 8'hD0;
   localparam logic [7:0] MARK_SOI  = 8'hD8;

   // One classified byte on its way from the parser to the mutator.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
      logic       pick;
      logic [3:0] roll;
      logic [2:0] flip_bit;
      logic [2:0] rotate_by;
      logic [7:0] fresh_byte;
      logic       in_scan;
      logic       safe;
   } entry_type;

endpackage

>>> hw/rtl/jsbm_front.sv
// Marker parser: walks the JPEG marker structure and tags each byte.
// Depends on jsbm_pkg for the marker codes and the queue entry type.
module jsbm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_file,
   input  logic                pick,
   input  logic [3:0]          roll,
   input  logic [2:0]          flip_bit,
   input  logic [2:0]          rotate_by,
   input  logic [7:0]          fresh_byte,
   output jsbm_pkg::entry_type entry
);

   typedef enum logic [3:0] {
      PH_SOI0, PH_SOI1, PH_SEEK, PH_MARK, PH_LENHI, PH_LENLO, PH_SKIP, PH_SCAN, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic        is_sos_ff, is_sos_in;
   logic        prev_ff_ff, prev_ff_in;

   logic        in_scan;
   logic        safe;
   logic [15:0] seg_len;
   logic [15:0] skip_dec;
   logic        byte_is_ff;

   assign byte_is_ff = (data_byte == jsbm_pkg::BYTE_FF);
   assign skip_dec   = skip_ff - 16'd1;

   always_comb begin
      seg_len = {len_hi_ff, data_byte};
      if (seg_len < 16'd2) begin
         seg_len = 16'd2;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      len_hi_in = len_hi_ff;
      is_sos_in = is_sos_ff;
      in_scan   = 1'b0;
      safe      = 1'b0;
      case (phase_ff)
         PH_SOI0: phase_in = PH_SOI1;
         PH_SOI1: phase_in = PH_SEEK;
         PH_SEEK: begin
            if (byte_is_ff) begin
               phase_in = PH_MARK;
            end
         end
         PH_MARK: begin
            if (byte_is_ff) begin
               phase_in = PH_MARK;
            end else if (data_byte == jsbm_pkg::BYTE_00) begin
               phase_in = PH_SEEK;
            end else if (data_byte == jsbm_pkg::MARK_EOI) begin
               phase_in = PH_DONE;
            end else if (data_byte >= jsbm_pkg::MARK_RST0 &&
                         data_byte <= jsbm_pkg::MARK_SOI) begin
               phase_in = PH_SEEK;
            end else begin
               is_sos_in = (data_byte == jsbm_pkg::MARK_SOS);
               phase_in  = PH_LENHI;
            end
         end
         PH_LENHI: begin
            len_hi_in = data_byte;
            phase_in  = PH_LENLO;
         end
         PH_LENLO: begin
            skip_in = seg_len - 16'd2;
            if (skip_in != 16'd0) begin
               phase_in = PH_SKIP;
            end else begin
               phase_in = is_sos_ff ? PH_SCAN : PH_SEEK;
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               phase_in = is_sos_ff ? PH_SCAN : PH_SEEK;
            end
         end
         PH_SCAN: begin
            in_scan = 1'b1;
            safe    = !byte_is_ff && !prev_ff_ff;
         end
         default: phase_in = PH_DONE;
      endcase
      prev_ff_in = byte_is_ff;
      // last byte of a file: start over for the next one
      if (end_of_file) begin
         phase_in   = PH_SOI0;
         skip_in    = 16'd0;
         len_hi_in  = 8'd0;
         is_sos_in  = 1'b0;
         prev_ff_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SOI0;
         skip_ff    <= 16'd0;
         len_hi_ff  <= 8'd0;
         is_sos_ff  <= 1'b0;
         prev_ff_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         skip_ff    <= skip_in;
         len_hi_ff  <= len_hi_in;
         is_sos_ff  <= is_sos_in;
         prev_ff_ff <= prev_ff_in;
      end
   end

   always_comb begin
      entry.data_byte   = data_byte;
      entry.end_of_file = end_of_file;
      entry.pick        = pick;
      entry.roll        = roll;
      entry.flip_bit    = flip_bit;
      entry.rotate_by   = rotate_by;
      entry.fresh_byte  = fresh_byte;
      entry.in_scan     = in_scan;
      entry.safe        = safe;
   end

endmodule

>>> hw/rtl/jsbm_queue.sv
// Small FIFO of classified bytes between the parser and the mutator.
// Depends on jsbm_pkg for the entry type.
module jsbm_queue #(
   parameter int unsigned DEPTH = jsbm_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsbm_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output jsbm_pkg::entry_type head_entry,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   jsbm_pkg::entry_type slots [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = slots[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/jsbm_back.sv
// Mutator and output register: applies flip, rotate or replace to picked safe bytes.
// Depends on jsbm_pkg; holds the corruption level register.
module jsbm_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [3:0]          csr_data,
   input  logic                head_valid,
   input  jsbm_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [2:0]          rsp_tuser
);

   logic [3:0] level_ff;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff;
   logic [2:0] user_ff, user_in;

   logic [3:0]  thresh;
   logic [7:0]  v;
   logic [7:0]  mutated;
   logic [15:0] rot_wide;

   assign v = head_entry.data_byte;

   // flip share is max(1, 10 - level)
   assign thresh   = (level_ff >= 4'd9) ? 4'd1 : jsbm_pkg::FLIP_BASE - level_ff;
   assign rot_wide = {v, v} << head_entry.rotate_by;

   always_comb begin
      if (head_entry.roll < thresh) begin
         mutated = v ^ (8'd1 << head_entry.flip_bit);
      end else if (head_entry.roll < jsbm_pkg::ROTATE_LIMIT) begin
         mutated = rot_wide[15:8];
      end else begin
         mutated = head_entry.fresh_byte;
      end
      if (mutated == jsbm_pkg::BYTE_FF) begin
         mutated = jsbm_pkg::BYTE_FE;
      end
      byte_in = (head_entry.safe && head_entry.pick) ? mutated : v;
      user_in = {head_entry.end_of_file && head_entry.in_scan,
                 head_entry.in_scan, head_entry.safe};
   end

   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= jsbm_pkg::LEVEL_RESET;
         valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            level_ff <= csr_data;
         end
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff <= byte_in;
         last_ff <= head_entry.end_of_file;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

>>> hw/rtl/jpeg_scan_byte_mutator.sv
// An accepted byte reaches its result through the parser into the queue, then the mutator register.
// Throughput: one byte per cycle; the parser keeps going while the queue has room, so
// the result side may stall for up to QUEUE_DEPTH items plus the output register.
// Reset (synchronous, active high): parser restarts at the first SOI byte, queue and
// output register empty, corruption level 5. The parser also restarts after each tlast.
module jpeg_scan_byte_mutator #(
   parameter int unsigned QUEUE_DEPTH = jsbm_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // data_byte[7:0], roll[11:8], flip_bit[14:12], rotate_by[17:15], fresh_byte[25:18]
   input  logic [31:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tlast,
   // pick[0]
   input  logic        req_tuser,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,
   // safe[0], in_scan[1], scan_found[2]
   output logic [2:0]  rsp_tuser,
   input  logic [3:0]  csr_data,
   input  logic        csr_valid,
   output logic        csr_ready
);

   jsbm_pkg::entry_type new_entry, head_entry;
   logic q_full, q_head_valid, q_pop, req_accept;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   jsbm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_tdata[7:0]),
      .end_of_file (req_tlast),
      .pick        (req_tuser),
      .roll        (req_tdata[11:8]),
      .flip_bit    (req_tdata[14:12]),
      .rotate_by   (req_tdata[17:15]),
      .fresh_byte  (req_tdata[25:18]),
      .entry       (new_entry)
   );

   jsbm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (new_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (head_entry),
      .count      (q_count)
   );

   jsbm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .head_valid (q_head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // a safe byte is always scan data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && !rsp_tuser[1]))
      else $error("safe result outside scan data");

   // scan_found only on the last result of a file, and only inside scan
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tlast && rsp_tuser[1]))
      else $error("scan_found on a result that is not last in scan");

   // queue occupancy never passes its depth
   assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue overflow");

   // an item leaves the queue only if it was there
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_count != '0)
      else $error("pop from empty queue");

endmodule

>>> tb/sv/jpeg_scan_byte_mutator_test.sv
// Self-checking testbench for jpeg_scan_byte_mutator: walks JPEG-like byte streams
// through the block and checks every result against a parser/mutator model kept here.
// Depends on jsbm_pkg and the jpeg_scan_byte_mutator RTL.
module jpeg_scan_byte_mutator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] MARK_APP0 = 8'hE0;
   localparam int unsigned IDLE_LIMIT = 1000;
   localparam int unsigned BYTES_PER_LEVEL = 95;

   typedef enum logic [3:0] {
      SOI_FIRST, SOI_SECOND, SEEK_FF, AT_MARKER, LEN_HIGH, LEN_LOW, SKIP_PAYLOAD,
      SCAN_DATA, PAST_EOI
   } parse_phase_type;

   typedef enum logic [1:0] {
      READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_BURSTY
   } sink_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
      logic       pick;
      logic [3:0] roll;
      logic [2:0] flip_bit;
      logic [2:0] rotate_by;
      logic [7:0] fresh_byte;
   } file_byte_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       safe;
      logic       in_scan;
      logic       last_out;
      logic       scan_found;
   } scan_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;
   logic [3:0]  csr_data = jsbm_pkg::LEVEL_RESET;
   logic        csr_valid = 1'b0;
   logic        csr_ready;

   jpeg_scan_byte_mutator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parser/mutator model state
   logic [3:0]      corruption_level = jsbm_pkg::LEVEL_RESET;
   parse_phase_type parse_phase = SOI_FIRST;
   logic [15:0]     skip_left = '0;
   logic [7:0]      length_high = '0;
   logic            segment_is_sos = 1'b0;
   logic            previous_was_ff = 1'b0;

   scan_result_type expected_results[$];
   logic [7:0]      file_q[$];
   int unsigned     error_count = 0;
   int unsigned     results_seen = 0;
   int unsigned     bytes_sent = 0;
   int unsigned     idle_cycles = 0;
   int unsigned     burst_left = 0;
   bit              sender_bursty = 1'b1;

   function automatic void append_byte(logic [7:0] b);
      file_q.insert(file_q.size(), b);
   endfunction

   function automatic void restart_parser();
      parse_phase = SOI_FIRST;
      skip_left = '0;
      length_high = '0;
      segment_is_sos = 1'b0;
      previous_was_ff = 1'b0;
   endfunction

   function automatic logic [7:0] mutated_byte(file_byte_type fb);
      logic [4:0] flip_below;
      logic [7:0] v;
      logic [7:0] r;
      v = fb.data_byte;
      flip_below = (corruption_level >= jsbm_pkg::FLIP_BASE) ? 5'd1 :
                   5'(jsbm_pkg::FLIP_BASE - corruption_level);
      if ({1'b0, fb.roll} < flip_below)
         r = v ^ (8'd1 << fb.flip_bit);
      else if (fb.roll < jsbm_pkg::ROTATE_LIMIT)
         r = (v << fb.rotate_by) | (v >> (4'd8 - fb.rotate_by));
      else
         r = fb.fresh_byte;
      if (r == jsbm_pkg::BYTE_FF)
         r = jsbm_pkg::BYTE_FE;
      return r;
   endfunction

   // Advances the marker walk by one byte and returns the result it should produce.
   function automatic scan_result_type parse_and_mutate(file_byte_type fb);
      scan_result_type res;
      logic [7:0]      b;
      logic [15:0]     seg_len;
      b = fb.data_byte;
      res = '{out_byte: b, safe: 1'b0, in_scan: 1'b0, last_out: fb.end_of_file,
              scan_found: 1'b0};
      case (parse_phase)
         SOI_FIRST:  parse_phase = SOI_SECOND;
         SOI_SECOND: parse_phase = SEEK_FF;
         SEEK_FF: begin
            if (b == jsbm_pkg::BYTE_FF)
               parse_phase = AT_MARKER;
         end
         AT_MARKER: begin
            if (b == jsbm_pkg::BYTE_FF)
               parse_phase = AT_MARKER;
            else if (b == jsbm_pkg::BYTE_00)
               parse_phase = SEEK_FF;
            else if (b == jsbm_pkg::MARK_EOI)
               parse_phase = PAST_EOI;
            else if (b >= jsbm_pkg::MARK_RST0 && b <= jsbm_pkg::MARK_SOI)
               parse_phase = SEEK_FF;
            else begin
               segment_is_sos = (b == jsbm_pkg::MARK_SOS);
               parse_phase = LEN_HIGH;
            end
         end
         LEN_HIGH: begin
            length_high = b;
            parse_phase = LEN_LOW;
         end
         LEN_LOW: begin
            seg_len = {length_high, b};
            if (seg_len < 16'd2)
               seg_len = 16'd2;
            skip_left = seg_len - 16'd2;
            if (skip_left != 0)
               parse_phase = SKIP_PAYLOAD;
            else
               parse_phase = segment_is_sos ? SCAN_DATA : SEEK_FF;
         end
         SKIP_PAYLOAD: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 0)
               parse_phase = segment_is_sos ? SCAN_DATA : SEEK_FF;
         end
         SCAN_DATA: begin
            res.in_scan = 1'b1;
            res.safe = (b != jsbm_pkg::BYTE_FF) && !previous_was_ff;
            if (res.safe && fb.pick)
               res.out_byte = mutated_byte(fb);
         end
         default: parse_phase = PAST_EOI;
      endcase
      previous_was_ff = (b == jsbm_pkg::BYTE_FF);
      res.scan_found = fb.end_of_file && res.in_scan;
      if (fb.end_of_file)
         restart_parser();
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      if (error_count < 30)
         $display("%0t ns: %s: got %02h, expected %02h (result %0d)",
                  $realtime, what, got, want, results_seen);
      error_count++;
   endtask

   // Results are taken at the negedge before the edge that completes the handshake;
   // rsp_tready only changes at posedges, so the pair is stable here.
   always @(negedge clock) begin : check_results
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_tdata, 8'h00);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata !== want.out_byte)
               report_mismatch("out_byte", rsp_tdata, want.out_byte);
            if (rsp_tuser[0] !== want.safe)
               report_mismatch("safe", 8'(rsp_tuser[0]), 8'(want.safe));
            if (rsp_tuser[1] !== want.in_scan)
               report_mismatch("in_scan", 8'(rsp_tuser[1]), 8'(want.in_scan));
            if (rsp_tlast !== want.last_out)
               report_mismatch("last", 8'(rsp_tlast), 8'(want.last_out));
            if (rsp_tuser[2] !== want.scan_found)
               report_mismatch("scan_found", 8'(rsp_tuser[2]), 8'(want.scan_found));
         end
         results_seen++;
      end
   end

   always @(negedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side back-pressure: switches between a few stall patterns.
   sink_mode_type sink_mode = READY_ALWAYS;
   int unsigned   mode_left = 0;
   int unsigned   hold_left = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(32, 256);
      end else begin
         mode_left--;
      end
      case (sink_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_RARELY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (hold_left == 0) begin
               rsp_tready <= !rsp_tready;
               hold_left = $urandom_range(1, 40);
            end else begin
               hold_left--;
            end
         end
      endcase
   end

   // Called at a posedge; returns at the posedge where the item was taken.
   task automatic send_byte(file_byte_type fb);
      if (sender_bursty) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
      end
      req_tdata  <= {6'd0, fb.fresh_byte, fb.rotate_by, fb.flip_bit, fb.roll, fb.data_byte};
      req_tlast  <= fb.end_of_file;
      req_tuser  <= fb.pick;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      expected_results.insert(expected_results.size(), parse_and_mutate(fb));
      bytes_sent++;
   endtask

   function automatic file_byte_type make_item(logic [7:0] b, int eof, int pick, int roll,
                                               int flip, int rot, logic [7:0] fresh);
      return '{data_byte: b, end_of_file: 1'(eof), pick: 1'(pick), roll: 4'(roll),
               flip_bit: 3'(flip), rotate_by: 3'(rot), fresh_byte: fresh};
   endfunction

   function automatic file_byte_type random_item(logic [7:0] b, logic eof);
      logic [3:0]    roll;
      logic [2:0]    rot;
      file_byte_type fb;
      roll = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      rot = ($urandom_range(0, 7) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      fb = '{data_byte: b, end_of_file: eof, pick: 1'($urandom_range(0, 1)), roll: roll,
             flip_bit: 3'($urandom_range(0, 7)), rotate_by: rot, fresh_byte: 8'($urandom)};
      return fb;
   endfunction

   // Waits for every outstanding result; the block is then idle (one result per item).
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_level(logic [3:0] level);
      drain_results();
      csr_data  <= level;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      corruption_level = level;
   endtask

   task automatic push_segment(logic [7:0] marker, logic [15:0] seg_len);
      append_byte(jsbm_pkg::BYTE_FF);
      append_byte(marker);
      append_byte(seg_len[15:8]);
      append_byte(seg_len[7:0]);
      if (seg_len > 16'd2)
         repeat (seg_len - 16'd2) append_byte(8'($urandom));
   endtask

   function automatic logic [15:0] random_length();
      int unsigned r;
      r = $urandom_range(0, 39);
      if (r < 3)
         return 16'($urandom_range(0, 1));
      else if (r == 3)
         return 16'h0100 + 16'($urandom_range(0, 15));
      else
         return 16'($urandom_range(2, 10));
   endfunction

   // Builds a mostly well-formed file: header segments, SOS, scan data, EOI.
   task automatic build_file();
      logic [7:0]  m;
      int unsigned cut;
      file_q.delete();
      if ($urandom_range(0, 9) == 0) begin
         append_byte(8'($urandom));
         append_byte(8'($urandom));
      end else begin
         append_byte(jsbm_pkg::BYTE_FF);
         append_byte(jsbm_pkg::MARK_SOI);
      end
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 5))
            0: begin
               append_byte(jsbm_pkg::BYTE_FF);
               append_byte(jsbm_pkg::BYTE_00);
            end
            1: begin
               append_byte(jsbm_pkg::BYTE_FF);
               append_byte(jsbm_pkg::BYTE_FF);
            end
            2: begin
               append_byte(jsbm_pkg::BYTE_FF);
               append_byte(8'($urandom_range(jsbm_pkg::MARK_RST0, jsbm_pkg::MARK_SOI)));
            end
            3: append_byte(8'($urandom_range(0, 254)));
            default: begin
               m = 8'($urandom_range(1, 254));
               if (m >= jsbm_pkg::MARK_RST0 && m <= jsbm_pkg::MARK_SOS)
                  m = MARK_APP0;
               push_segment(m, random_length());
            end
         endcase
      end
      if ($urandom_range(0, 9) == 0) begin
         // end of image before any scan; trailing bytes are ignored
         append_byte(jsbm_pkg::BYTE_FF);
         append_byte(jsbm_pkg::MARK_EOI);
         repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
      end else begin
         push_segment(jsbm_pkg::MARK_SOS, random_length());
         repeat ($urandom_range(4, 40)) begin
            case ($urandom_range(0, 9))
               0: begin
                  append_byte(jsbm_pkg::BYTE_FF);
                  append_byte(jsbm_pkg::BYTE_00);
               end
               1: begin
                  append_byte(jsbm_pkg::BYTE_FF);
                  append_byte(8'($urandom_range(jsbm_pkg::MARK_RST0,
                                                jsbm_pkg::MARK_RST0 + 7)));
               end
               2: append_byte(jsbm_pkg::BYTE_FF);
               default: append_byte(8'($urandom));
            endcase
         end
         if ($urandom_range(0, 7) != 0) begin
            append_byte(jsbm_pkg::BYTE_FF);
            append_byte(jsbm_pkg::MARK_EOI);
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, file_q.size());
         while (file_q.size() > cut) void'(file_q.pop_back());
      end
   endtask

   task automatic send_file();
      foreach (file_q[i])
         send_byte(random_item(file_q[i], i == file_q.size() - 1));
   endtask

   task automatic test_marker_walk_and_mutations();
      // level 5 from reset: rolls 0..4 flip, 5..6 rotate, 7 and up replace
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_SOI,  0, 1, 0, 0, 0, 8'h00));
      // APP0 with a length of 1, counted as 2
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(MARK_APP0,           0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(8'h00,               0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(8'h01,               0, 1, 0, 0, 0, 8'h00));
      // stuffed zero, fill byte, restart marker
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::BYTE_00,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_RST0, 0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_SOS,  0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(8'h00,               0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(8'h02,               0, 1, 0, 0, 0, 8'h00));
      // flip of bit 7 lands on FF and is turned into FE
      send_byte(make_item(8'h7F,               0, 1, 0,  7, 0, 8'h00));
      // rotate by zero leaves the byte alone
      send_byte(make_item(8'h00,               0, 1, 5,  0, 0, 8'hFF));
      send_byte(make_item(8'h81,               0, 1, 6,  0, 7, 8'h00));
      send_byte(make_item(8'h12,               0, 1, 9,  0, 1, 8'hFF));
      send_byte(make_item(8'h34,               0, 1, 15, 7, 7, 8'h00));
      send_byte(make_item(8'h56,               0, 0, 0,  0, 0, 8'hAA));
      // FF and the byte after it are never safe
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0,  0, 0, 8'h00));
      send_byte(make_item(8'h00,               0, 1, 0,  0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0,  0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_EOI,  1, 1, 0,  0, 0, 8'h00));
      // end of image before SOS
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_SOI,  0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_EOI,  1, 1, 0, 0, 0, 8'h00));
      // file ends on the last byte of the SOS header
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_SOI,  0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::BYTE_FF,   0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(jsbm_pkg::MARK_SOS,  0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(8'h00,               0, 1, 0, 0, 0, 8'h00));
      send_byte(make_item(8'h01,               1, 1, 0, 0, 0, 8'h00));
   endtask

   task automatic test_random_files_per_level();
      logic [3:0]  levels[9];
      int unsigned start;
      levels = '{4'd1, 4'd10, 4'd0, 4'd15, 4'd11, 4'd5, 4'd7, 4'($urandom), 4'($urandom)};
      foreach (levels[i]) begin
         write_level(levels[i]);
         sender_bursty = (i != 2);
         burst_left = 0;
         start = bytes_sent;
         while (bytes_sent - start < BYTES_PER_LEVEL) begin
            build_file();
            send_file();
         end
      end
      sender_bursty = 1'b1;
   endtask

   task automatic test_noise_files();
      write_level(4'($urandom_range(1, 9)));
      repeat (8) begin
         file_q.delete();
         repeat ($urandom_range(2, 15)) append_byte(8'($urandom));
         send_file();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      corruption_level = jsbm_pkg::LEVEL_RESET;
      restart_parser();
      test_marker_walk_and_mutations();
      test_random_files_per_level();
      test_noise_files();
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
